// ===== rtl/chavg_pkg.sv =====
// Shared widths, defaults and types of the cascaded history averager.
`default_nettype none

package chavg_pkg;

   localparam int ADC_W                 = 12;
   localparam int TEMP_W                = 19;
   localparam int HISTORY_DEPTH_DEFAULT = 8;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_READ   = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   typedef struct packed {
      logic [ADC_W-1:0]         adc;
      logic signed [TEMP_W-1:0] temp;
   } hist_entry_type;

endpackage

`default_nettype wire

// ===== rtl/chavg_divider.sv =====
// Restoring unsigned divider that produces one quotient bit per cycle.
`default_nettype none

module chavg_divider #(
   parameter int W  = 23,
   parameter int DW = 4
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [W-1:0]  dividend,
   input  wire logic [DW-1:0] divisor,
   output logic               done,
   output logic [W-1:0]       quotient
);
   import chavg_pkg::*;

   localparam int CW = $clog2(W + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] count_ff, count_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [DW-1:0] div_ff, div_in;
   logic [DW:0]   shifted;
   logic [DW:0]   diff;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      div_in   = div_ff;
      shifted  = {rem_ff, quo_ff[W-1]};
      diff     = shifted - {1'b0, div_ff};
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend;
         div_in   = divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = diff[DW-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DW-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == CW'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== rtl/cascaded_history_averager.sv =====
// Top level of the cascaded history averager: sequencer, history memory and accumulators.
// Each request beat carries a converter code and a signed temperature with 8 fraction bits;
// the block adds them to every stored past average, divides both sums by the number of
// terms with truncation toward zero, returns the two averages as one response beat and
// stores them in a circular history of HISTORY_DEPTH entries. One item at a time is
// processed: after acceptance, the history is read one entry a cycle through the single
// read port and summed, both sums then pass through the one-bit-per-cycle dividers, and
// the averages are written back once the output register is free. A new request is taken
// while a finished response still waits in the output register.
`default_nettype none

module cascaded_history_averager #(
   parameter int HISTORY_DEPTH = chavg_pkg::HISTORY_DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [chavg_pkg::ADC_W-1:0]         req_adc_code,
   input  wire logic signed [chavg_pkg::TEMP_W-1:0] req_temp_sample,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [chavg_pkg::ADC_W-1:0]              rsp_adc_average,
   output logic signed [chavg_pkg::TEMP_W-1:0]      rsp_temp_average
);
   import chavg_pkg::*;

   localparam int PW    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNTW  = $clog2(HISTORY_DEPTH + 1);
   localparam int TERMW = $clog2(HISTORY_DEPTH + 2);
   localparam int SUMX  = $clog2(HISTORY_DEPTH + 1);
   localparam int AW    = ADC_W + SUMX;
   localparam int TW    = TEMP_W + SUMX;

   state_type      state_ff, state_in;
   logic [PW-1:0]  wp_ff, wp_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [CNTW-1:0] rd_idx_ff, rd_idx_in;
   logic           rd_pend_ff, rd_pend_in;
   logic [AW-1:0]  adc_acc_ff, adc_acc_in;
   logic [TW-1:0]  temp_acc_ff, temp_acc_in;
   logic           temp_neg_ff, temp_neg_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [ADC_W-1:0] rsp_adc_ff, rsp_adc_in;
   logic [TEMP_W-1:0] rsp_temp_ff, rsp_temp_in;

   hist_entry_type mem [HISTORY_DEPTH];
   hist_entry_type rd_data_ff;
   hist_entry_type wr_data;
   logic           rd_en;
   logic           wr_en;

   logic           div_start;
   logic           adc_div_done;
   logic           temp_div_done;
   logic [TW-1:0]  adc_dividend;
   logic [TW-1:0]  temp_dividend;
   logic [TERMW-1:0] divisor;
   logic [TW-1:0]  adc_quo;
   logic [TW-1:0]  temp_quo;
   logic [TW-1:0]  temp_signed_quo;
   logic           rsp_free;

   assign rsp_free      = !rsp_valid_ff || rsp_ready;
   assign adc_dividend  = {{(TW - AW){1'b0}}, adc_acc_ff};
   assign temp_dividend = temp_acc_ff[TW-1] ? (~temp_acc_ff + 1'b1) : temp_acc_ff;
   assign divisor       = TERMW'(cnt_ff) + 1'b1;
   assign temp_signed_quo = temp_neg_ff ? (~temp_quo + 1'b1) : temp_quo;
   assign wr_data.adc   = adc_quo[ADC_W-1:0];
   assign wr_data.temp  = temp_signed_quo[TEMP_W-1:0];

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      cnt_in       = cnt_ff;
      rd_idx_in    = rd_idx_ff;
      rd_pend_in   = 1'b0;
      adc_acc_in   = adc_acc_ff;
      temp_acc_in  = temp_acc_ff;
      temp_neg_in  = temp_neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_adc_in   = rsp_adc_ff;
      rsp_temp_in  = rsp_temp_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      div_start    = 1'b0;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               adc_acc_in  = {{SUMX{1'b0}}, req_adc_code};
               temp_acc_in = {{SUMX{req_temp_sample[TEMP_W-1]}}, req_temp_sample};
               rd_idx_in   = '0;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            if (rd_idx_ff < cnt_ff) begin
               rd_en      = 1'b1;
               rd_idx_in  = rd_idx_ff + 1'b1;
               rd_pend_in = 1'b1;
            end
            if (rd_pend_ff) begin
               adc_acc_in  = adc_acc_ff + {{SUMX{1'b0}}, rd_data_ff.adc};
               temp_acc_in = temp_acc_ff
                           + {{SUMX{rd_data_ff.temp[TEMP_W-1]}}, rd_data_ff.temp};
            end else if (rd_idx_ff == cnt_ff) begin
               div_start   = 1'b1;
               temp_neg_in = temp_acc_ff[TW-1];
               state_in    = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (adc_div_done && temp_div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               wr_en        = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_adc_in   = wr_data.adc;
               rsp_temp_in  = wr_data.temp;
               wp_in        = (wp_ff == PW'(HISTORY_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
               if (cnt_ff != CNTW'(HISTORY_DEPTH)) begin
                  cnt_in = cnt_ff + 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         cnt_ff       <= '0;
         rd_idx_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         cnt_ff       <= cnt_in;
         rd_idx_ff    <= rd_idx_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      adc_acc_ff  <= adc_acc_in;
      temp_acc_ff <= temp_acc_in;
      temp_neg_ff <= temp_neg_in;
      rsp_adc_ff  <= rsp_adc_in;
      rsp_temp_ff <= rsp_temp_in;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_idx_ff[PW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wp_ff] <= wr_data;
      end
   end

   chavg_divider #(
      .W  (TW),
      .DW (TERMW)
   ) u_div_adc (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (adc_dividend),
      .divisor  (divisor),
      .done     (adc_div_done),
      .quotient (adc_quo)
   );

   chavg_divider #(
      .W  (TW),
      .DW (TERMW)
   ) u_div_temp (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (temp_dividend),
      .divisor  (divisor),
      .done     (temp_div_done),
      .quotient (temp_quo)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_adc_average  = rsp_adc_ff;
   assign rsp_temp_average = rsp_temp_ff;

endmodule

`default_nettype wire
